### rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

    // Default sizing
    localparam int unsigned DEF_CAPACITY   = 64;
    localparam int unsigned DEF_DATA_WIDTH = 32;

    // Fixed field widths of the item ports
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned DIN_W    = 32;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned DOUT_W   = 32;
    localparam int unsigned FIDX_W   = 6;
    localparam int unsigned SIZE_W   = 7;

    // Operation codes carried on func
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_READ   = 2'd2,
        FN_SEARCH = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_INVALID  = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    // Command broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_READ,
        CELL_SEARCH
    } cell_op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIND
    } ctl_state_t;

endpackage

### rtl/ple_cell.sv
// One list cell: holds one entry, shifts with its neighbors, compares locally.
`timescale 1ns / 1ps

module ple_cell
    import ple_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int unsigned IDX_W      = 6,
    parameter int unsigned CNT_W      = 7,
    parameter int unsigned INDEX      = 0
)
(
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic [IDX_W-1:0]      idx,
    input  logic [CNT_W-1:0]      cnt,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  match,
    output logic [DATA_WIDTH-1:0] sel_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  at_idx;
    logic                  past_idx;
    logic                  occupied;

    assign at_idx   = (idx == MY_IDX);
    assign past_idx = (MY_IDX > idx);
    assign occupied = (MY_CNT < cnt);

    // Shift toward the tail on insert, toward the head on remove
    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            CELL_INSERT:
            begin
                if (past_idx)
                    data_next = left_data;
                else if (at_idx)
                    data_next = value;
            end
            CELL_REMOVE:
            begin
                if (past_idx || at_idx)
                    data_next = right_data;
            end
            CELL_HOLD, CELL_READ, CELL_SEARCH:
            begin
                data_next = data_reg;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

    // Local compare for search, gated read-out for read and remove
    assign match    = (op == CELL_SEARCH) && occupied && (data_reg == value);
    assign sel_data = ((op == CELL_READ || op == CELL_REMOVE) && at_idx) ?
                      data_reg : '0;

endmodule

### rtl/positional_list_engine_core.sv
// Top level of the positional list engine: sequencer, decode and the cell row.
`timescale 1ns / 1ps

// Bounded ordered list of signed words held in a row of CAPACITY cells, one
// entry per cell. Each insert, remove, read or search passes accept, execute
// and result steps: accept latches the request, execute has every cell compare
// its own index or value and, on insert or remove, the cells from the index on
// shift by one place toward a neighbor, and result encodes the first match and
// loads the output register. A new item is taken only once the last result is
// loaded; a result waiting in the output register holds the sequencer only when
// the next result is ready to be loaded. No clearing pass follows reset: the
// element count starts at zero and entries are written before they are read.

module positional_list_engine_core
    import ple_pkg::*;
#(
    parameter int unsigned CAPACITY   = DEF_CAPACITY,
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [POS_W-1:0]  position,
    input  logic signed [DIN_W-1:0]  data_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STAT_W-1:0]        status,
    output logic signed [DOUT_W-1:0] data_out,
    output logic [FIDX_W-1:0]        found_index,
    output logic [SIZE_W-1:0]        size_before
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // Latched request
    func_t                  func_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [DATA_WIDTH-1:0]  val_reg;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       size0_reg;

    // Execute-stage results
    status_t                stat_reg;
    logic [CAPACITY-1:0]    match_reg;
    logic [DATA_WIDTH-1:0]  rd_reg;

    // Output register
    logic                   out_valid_reg;
    status_t                out_stat_reg;
    logic [DOUT_W-1:0]      out_data_reg;
    logic [FIDX_W-1:0]      out_fidx_reg;
    logic [SIZE_W-1:0]      out_size_reg;

    // Decode
    logic                   pos_neg;
    logic                   pos_tail;
    logic                   pos_below;
    logic [CMP_W-1:0]       pos_u;
    logic [CMP_W-1:0]       cnt_c;
    logic                   pos_past;
    status_t                stat_calc;
    cell_op_t               cell_op;
    logic [IDX_W-1:0]       cell_idx;
    logic [CNT_W-1:0]       count_last;

    // Cell row wiring
    logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0]  cell_sel  [CAPACITY];
    logic [CAPACITY-1:0]    cell_match;
    logic [DATA_WIDTH-1:0]  rd_or;

    // Result encode
    logic [IDX_W-1:0]       fidx;
    logic                   any_match;
    status_t                res_stat;
    logic signed [DATA_WIDTH-1:0] res_data;
    logic                   out_load;
    logic                   in_xfer;

    assign in_xfer = in_valid && in_ready;

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_FIND;
            end
            ST_FIND:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                in_ready = 1'b0;
            end
            ST_FIND:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Request latch
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg <= func_t'(func);
            pos_reg  <= position;
            val_reg  <= DATA_WIDTH'(data_in);
        end
    end

    // Position decode against the current count
    assign pos_neg    = pos_reg[POS_W-1];
    assign pos_tail   = (pos_reg == {POS_W{1'b1}});
    assign pos_below  = pos_neg && !pos_tail;
    assign pos_u      = CMP_W'(pos_reg[POS_W-2:0]);
    assign cnt_c      = CMP_W'(count_reg);
    assign pos_past   = !pos_neg && (pos_u >= cnt_c);
    assign count_last = count_reg - CNT_W'(1);

    always_comb
    begin
        stat_calc  = STAT_OK;
        cell_op    = CELL_HOLD;
        cell_idx   = pos_u[IDX_W-1:0];
        count_next = count_reg;
        unique case (func_reg)
            FN_INSERT:
            begin
                if (pos_below)
                    stat_calc = STAT_INVALID;
                else if (count_reg == CAP_CNT)
                    stat_calc = STAT_FULL;
                else
                begin
                    cell_op    = CELL_INSERT;
                    count_next = count_reg + CNT_W'(1);
                    if (pos_tail || pos_past)
                        cell_idx = count_reg[IDX_W-1:0];
                end
            end
            FN_REMOVE, FN_READ:
            begin
                if (count_reg == '0 || pos_below || pos_past)
                    stat_calc = STAT_INVALID;
                else
                begin
                    cell_op = (func_reg == FN_REMOVE) ? CELL_REMOVE : CELL_READ;
                    if (pos_tail)
                        cell_idx = count_last[IDX_W-1:0];
                    if (func_reg == FN_REMOVE)
                        count_next = count_last;
                end
            end
            FN_SEARCH:
            begin
                if (count_reg == '0)
                    stat_calc = STAT_INVALID;
                else
                    cell_op = CELL_SEARCH;
            end
            default:
            begin
                stat_calc = STAT_INVALID;
            end
        endcase
    end

    // Cell row
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (g == 0)
        begin : g_head
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[g+1];
        end

        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .clk        (clk),
            .op         ((state_reg == ST_EXEC) ? cell_op : CELL_HOLD),
            .idx        (cell_idx),
            .cnt        (count_reg),
            .value      (val_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g]),
            .match      (cell_match[g]),
            .sel_data   (cell_sel[g])
        );
    end

    // Collect the one selected entry
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_or = rd_or | cell_sel[i];
    end

    // Count and execute-stage capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (state_reg == ST_EXEC)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            size0_reg <= count_reg;
            stat_reg  <= stat_calc;
            match_reg <= cell_match;
            rd_reg    <= rd_or;
        end
    end

    // First match wins
    always_comb
    begin
        fidx      = '0;
        any_match = |match_reg;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_reg[i])
                fidx = IDX_W'(i);
        end
    end

    always_comb
    begin
        res_stat = stat_reg;
        res_data = '0;
        if (stat_reg == STAT_OK)
        begin
            if (func_reg == FN_SEARCH && !any_match)
                res_stat = STAT_NOTFOUND;
            if (func_reg == FN_REMOVE || func_reg == FN_READ)
                res_data = rd_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_stat_reg <= res_stat;
            out_data_reg <= DOUT_W'(res_data);
            out_fidx_reg <= (res_stat == STAT_OK && func_reg == FN_SEARCH) ?
                            FIDX_W'(fidx) : '0;
            out_size_reg <= SIZE_W'(size0_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_stat_reg;
    assign data_out    = out_data_reg;
    assign found_index = out_fidx_reg;
    assign size_before = out_size_reg;

endmodule

### dv/positional_list_engine_core_test.sv
// Self-checking testbench for the positional list engine core.
`timescale 1ns / 1ps

module positional_list_engine_core_test;
    import ple_pkg::*;

    localparam int LIST_DEPTH   = DEF_CAPACITY;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    // One result transfer as seen on the output ports
    typedef struct packed {
        status_t     status;
        logic [31:0] data_out;
        logic [5:0]  found_index;
        logic [6:0]  size_before;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  position;
    logic signed [DIN_W-1:0]  data_in;
    logic                     out_valid;
    logic                     out_ready;
    logic [STAT_W-1:0]        status;
    logic signed [DOUT_W-1:0] data_out;
    logic [FIDX_W-1:0]        found_index;
    logic [SIZE_W-1:0]        size_before;

    // Shadow copy of the list contents, head at index 0
    logic signed [31:0] list_shadow[$];
    // Results owed by the block, oldest first
    list_result_t       owed_results[$];

    int mismatches;
    int cycles;
    int max_gap;
    int max_stall;
    bit hold_off;

    positional_list_engine_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .position    (position),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .data_out    (data_out),
        .found_index (found_index),
        .size_before (size_before)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, owed_results.size());
            $display("** positional_list_engine_core: FAILED **");
            $finish;
        end
    end

    // Apply one operation to the shadow list and return what the block owes for it
    function automatic list_result_t apply_list_op(func_t op, logic signed [8:0] pos,
                                                   logic signed [31:0] value);
        list_result_t r;
        int p;
        int n;
        int idx;
        int i;
        p = pos;
        n = list_shadow.size();
        r = '0;
        r.status = STAT_OK;
        r.size_before = n[6:0];
        case (op)
            FN_INSERT:
            begin
                // bad position wins over a full list
                if (p < -1)
                    r.status = STAT_INVALID;
                else if (n >= LIST_DEPTH)
                    r.status = STAT_FULL;
                else if (p == -1 || p >= n)
                    list_shadow.push_back(value);
                else
                    list_shadow.insert(p, value);
            end
            FN_REMOVE, FN_READ:
            begin
                if (n == 0 || p < -1 || p >= n)
                    r.status = STAT_INVALID;
                else
                begin
                    idx = (p == -1) ? n - 1 : p;
                    r.data_out = list_shadow[idx];
                    if (op == FN_REMOVE)
                        list_shadow.delete(idx);
                end
            end
            default:
            begin
                if (n == 0)
                    r.status = STAT_INVALID;
                else
                begin
                    r.status = STAT_NOTFOUND;
                    for (i = 0; i < n; i++)
                    begin
                        if (list_shadow[i] == value)
                        begin
                            r.status = STAT_OK;
                            r.found_index = i[5:0];
                            break;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Offer one operation after a random gap; record its result once the transfer happens
    task automatic send_op(input func_t op, input int pos, input logic [31:0] value);
        int gap;
        logic signed [8:0] pos9;
        gap = $urandom_range(0, max_gap);
        pos9 = pos[8:0];
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        position <= pos9;
        data_in  <= value;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        owed_results.push_back(apply_list_op(op, pos9, value));
    endtask

    // Mostly in-range positions, with the tail, one past the end and raw noise
    function automatic int pick_position();
        int n;
        int r;
        n = list_shadow.size();
        r = $urandom_range(0, 99);
        if (r < 10)
            return -1;
        if (r < 22)
            return int'($urandom_range(0, 511)) - 256;
        if (r < 28 || n == 0)
            return n;
        return $urandom_range(0, n - 1);
    endfunction

    // Small values repeat often so searches hit; extremes and full-range words too
    function automatic logic [31:0] pick_value(func_t op);
        int r;
        r = $urandom_range(0, 99);
        if (op == FN_SEARCH && list_shadow.size() != 0 && r < 60)
            return list_shadow[$urandom_range(0, list_shadow.size() - 1)];
        if (r < 45)
            return int'($urandom_range(0, 15)) - 8;
        if (r < 50)
            return 32'h8000_0000;
        if (r < 55)
            return 32'h7fff_ffff;
        return $urandom();
    endfunction

    // Empty-list errors, bad positions, appends, middle inserts, duplicates
    task automatic test_directed();
        max_gap   = 3;
        max_stall = 3;
        send_op(FN_READ,     0,    32'd0);
        send_op(FN_REMOVE,  -1,    32'd0);
        send_op(FN_SEARCH,   0,    32'd0);
        send_op(FN_INSERT,  -2,    32'd5);
        send_op(FN_INSERT,  -256,  32'd6);
        send_op(FN_INSERT,  -1,    32'h7fff_ffff);
        send_op(FN_INSERT,   0,    32'h8000_0000);
        send_op(FN_INSERT,   255,  32'hffff_ffff);
        send_op(FN_INSERT,   1,    32'd42);
        send_op(FN_INSERT,   2,    32'd42);
        send_op(FN_READ,    -1,    32'd0);
        send_op(FN_READ,     0,    32'd0);
        send_op(FN_READ,     5,    32'd0);
        send_op(FN_READ,    -2,    32'd0);
        send_op(FN_READ,     255,  32'd0);
        send_op(FN_SEARCH,   0,    32'd42);
        send_op(FN_SEARCH,   0,    32'd7);
        send_op(FN_SEARCH,   0,    32'h8000_0000);
        send_op(FN_REMOVE,   2,    32'd0);
        send_op(FN_REMOVE,  -1,    32'd0);
        send_op(FN_REMOVE,   0,    32'd0);
        send_op(FN_REMOVE,  -3,    32'd0);
        send_op(FN_REMOVE,   5,    32'd0);
        send_op(FN_SEARCH,  -256,  32'd42);
    endtask

    // Fill to capacity with unique words, probe the full list, then drain it
    task automatic test_fill_drain();
        int last;
        max_gap   = 2;
        max_stall = 2;
        while (list_shadow.size() < LIST_DEPTH)
            send_op(FN_INSERT, pick_position(), 32'h1000_0000 + $urandom_range(0, 4095) * 4096
                    + list_shadow.size());
        send_op(FN_INSERT,  5,    32'd1);
        send_op(FN_INSERT, -1,    32'd1);
        send_op(FN_INSERT, -2,    32'd1);
        send_op(FN_INSERT, -256,  32'd1);
        send_op(FN_READ,    63,   32'd0);
        send_op(FN_READ,    64,   32'd0);
        last = list_shadow.size() - 1;
        send_op(FN_SEARCH,  0,    list_shadow[last]);
        while (list_shadow.size() != 0)
            send_op(FN_REMOVE, pick_position(), $urandom());
    endtask

    // Receiver holds off long enough for the block to back up and stall its input
    task automatic test_backpressure();
        int k;
        func_t op;
        max_gap = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        for (k = 0; k < 40; k++)
        begin
            op = (k < 20) ? FN_INSERT : func_t'($urandom_range(0, 3));
            send_op(op, pick_position(), pick_value(op));
        end
    endtask

    // Random operations in segments with varied idling and insert bias
    task automatic test_random_ops(input int n_items);
        int done;
        int w_ins;
        int r;
        func_t op;
        done = 0;
        while (done < n_items)
        begin
            case ($urandom_range(0, 2))
                0:       max_gap = 0;
                1:       max_gap = 4;
                default: max_gap = 16;
            endcase
            case ($urandom_range(0, 2))
                0:       max_stall = 0;
                1:       max_stall = 4;
                default: max_stall = 16;
            endcase
            case ($urandom_range(0, 2))
                0:       w_ins = 25;
                1:       w_ins = 45;
                default: w_ins = 85;
            endcase
            repeat (40)
            begin
                r = $urandom_range(0, 99);
                if (r < w_ins)
                    op = FN_INSERT;
                else if (r < w_ins + (100 - w_ins) / 3)
                    op = FN_REMOVE;
                else if (r < w_ins + 2 * (100 - w_ins) / 3)
                    op = FN_READ;
                else
                    op = FN_SEARCH;
                send_op(op, pick_position(), pick_value(op));
                done++;
            end
        end
    endtask

    // Result side: random stall per transfer, plus the long hold-off
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, max_stall);
            if (stall != 0 || hold_off)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // Compare each result transfer with the oldest owed result
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {status, data_out, found_index, size_before};
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("cycle %0d: unexpected result status=%0d data_out=%0d idx=%0d size=%0d",
                             cycles, got.status, $signed(got.data_out), got.found_index,
                             got.size_before);
            end
            else
            begin
                want = owed_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("cycle %0d: mismatch", cycles);
                        $display("  expected status=%0d data_out=%0d idx=%0d size=%0d",
                                 want.status, $signed(want.data_out), want.found_index,
                                 want.size_before);
                        $display("  actual   status=%0d data_out=%0d idx=%0d size=%0d",
                                 got.status, $signed(got.data_out), got.found_index,
                                 got.size_before);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FN_INSERT;
        position  = '0;
        data_in   = '0;
        hold_off  = 1'b0;
        max_gap   = 0;
        max_stall = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_drain();
        test_backpressure();
        test_random_ops(760);

        in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("** positional_list_engine_core: PASSED **");
        else
            $display("** positional_list_engine_core: FAILED **");
        $finish;
    end

endmodule
